[sv/cpfm_pkg.sv]
package cpfm_pkg;

    localparam int CHANNELS_DEF = 2;

    localparam int STAMP_W   = 16;
    localparam int CLOCK_W   = 27;
    localparam int TIMEOUT_W = 8;
    localparam int MOD_W     = STAMP_W + 1;

    // shared divider: dividend is left aligned, one quotient bit per step
    localparam int DIV_W    = CLOCK_W;
    localparam int DIV_CNT_W = $clog2(DIV_W + 1);
    localparam int DIV_PAD_W = DIV_W - STAMP_W;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [CLOCK_W-1:0]   CLOCK_RESET   = CLOCK_W'(2222);
    localparam logic [STAMP_W-1:0]   TOP_RESET     = STAMP_W'(65535);
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = TIMEOUT_W'(15);
    localparam logic [TIMEOUT_W-1:0] MS_MAX        = '1;
    localparam logic [STAMP_W-1:0]   FREQ_MAX      = '1;

    typedef enum logic [1:0] {
        KIND_CAPTURE = 2'd0,
        KIND_TICK    = 2'd1,
        KIND_POLL    = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        REG_CLOCK   = 2'd0,
        REG_TOP     = 2'd1,
        REG_TIMEOUT = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic [1:0]         kind;
        logic               channel;
        logic [STAMP_W-1:0] first_stamp;
        logic [STAMP_W-1:0] second_stamp;
    } in_word_t;

    typedef struct packed {
        logic               result_channel;
        logic [STAMP_W-1:0] period_ticks;
        logic [STAMP_W-1:0] frequency_hz;
    } res_word_t;

    typedef struct packed {
        logic     valid;
        in_word_t cmd;
    } cmd_link_t;

    typedef struct packed {
        logic                 start;
        logic [DIV_W-1:0]     dividend;
        logic [MOD_W-1:0]     divisor;
        logic [DIV_CNT_W-1:0] steps;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
        logic [MOD_W-1:0] remainder;
    } div_rsp_t;

endpackage

[sv/cpfm_front.sv]
module cpfm_front #(
    parameter int CHANNELS = cpfm_pkg::CHANNELS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  cpfm_pkg::in_word_t  item,
    output cpfm_pkg::cmd_link_t link,
    input  logic                ready
);

    localparam int DEPTH = cpfm_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

    cpfm_pkg::in_word_t slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    logic keep;
    logic wr_en;
    logic rd_en;

    // ticks go to every channel; captures and polls need a channel that exists
    always_comb
    begin
        keep = 1'b0;
        case (item.kind)
            cpfm_pkg::KIND_TICK:
                keep = 1'b1;
            cpfm_pkg::KIND_CAPTURE,
            cpfm_pkg::KIND_POLL:
                keep = (32'(item.channel) < 32'(CHANNELS));
            default:
                keep = 1'b0;
        endcase
    end

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign wr_en = push & ~full & keep;
    assign rd_en = link.valid & ready;

    assign link.valid = (count_reg != '0);
    assign link.cmd   = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (rd_en)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (rd_en && !wr_en)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_reg[wr_ptr_reg] <= item;
        end
    end

endmodule

[sv/cpfm_div.sv]
module cpfm_div (
    input  logic               clk,
    input  logic               rst_n,
    input  cpfm_pkg::div_req_t req,
    output cpfm_pkg::div_rsp_t rsp
);

    localparam int DIV_W = cpfm_pkg::DIV_W;
    localparam int MOD_W = cpfm_pkg::MOD_W;
    localparam int CNT_W = cpfm_pkg::DIV_CNT_W;

    logic [DIV_W-1:0] quo_reg, quo_next;
    logic [MOD_W-1:0] rem_reg, rem_next;
    logic [MOD_W-1:0] dsr_reg, dsr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;

    logic [MOD_W:0]   partial;
    logic [MOD_W+1:0] trial;

    // restoring step: shift in the next dividend bit, subtract if it fits
    assign partial = {rem_reg, quo_reg[DIV_W-1]};
    assign trial   = {1'b0, partial} - {2'b00, dsr_reg};

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            quo_next  = req.dividend;
            rem_next  = '0;
            dsr_next  = req.divisor;
            cnt_next  = req.steps;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[MOD_W+1])
            begin
                rem_next = trial[MOD_W-1:0];
                quo_next = {quo_reg[DIV_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = partial[MOD_W-1:0];
                quo_next = {quo_reg[DIV_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

endmodule

[sv/cpfm_back.sv]
module cpfm_back #(
    parameter int CHANNELS = cpfm_pkg::CHANNELS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  cpfm_pkg::cmd_link_t link,
    output logic                ready,
    input  logic                cfg_write,
    input  logic [1:0]          cfg_index,
    input  logic [cpfm_pkg::CLOCK_W-1:0] cfg_data,
    output logic                empty,
    input  logic                pop,
    output cpfm_pkg::res_word_t result
);

    localparam int STAMP_W   = cpfm_pkg::STAMP_W;
    localparam int CLOCK_W   = cpfm_pkg::CLOCK_W;
    localparam int TIMEOUT_W = cpfm_pkg::TIMEOUT_W;
    localparam int MOD_W     = cpfm_pkg::MOD_W;
    localparam int CH_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_MOD  = 4'b0010,
        ST_FREQ = 4'b0100,
        ST_OUT  = 4'b1000
    } back_state_t;

    back_state_t state_reg, state_next;

    logic [CLOCK_W-1:0]   clock_reg, clock_next;
    logic [STAMP_W-1:0]   top_reg, top_next;
    logic [TIMEOUT_W-1:0] timeout_reg, timeout_next;

    logic [STAMP_W-1:0]   first_reg [CHANNELS];
    logic [STAMP_W-1:0]   first_next [CHANNELS];
    logic [STAMP_W-1:0]   second_reg [CHANNELS];
    logic [STAMP_W-1:0]   second_next [CHANNELS];
    logic [STAMP_W-1:0]   per_reg [CHANNELS];
    logic [STAMP_W-1:0]   per_next [CHANNELS];
    logic [STAMP_W-1:0]   freq_reg [CHANNELS];
    logic [STAMP_W-1:0]   freq_next [CHANNELS];
    logic [TIMEOUT_W-1:0] ms_reg [CHANNELS];
    logic [TIMEOUT_W-1:0] ms_next [CHANNELS];
    logic [CHANNELS-1:0]  pend_reg, pend_next;
    logic [CHANNELS-1:0]  cap_reg, cap_next;

    logic [CH_W-1:0]    ch_reg, ch_next;
    logic               neg_reg, neg_next;
    logic [STAMP_W-1:0] p_reg, p_next;
    logic [STAMP_W-1:0] f_reg, f_next;

    logic                out_valid_reg, out_valid_next;
    cpfm_pkg::res_word_t out_reg, out_next;

    cpfm_pkg::div_req_t div_req;
    cpfm_pkg::div_rsp_t div_rsp;

    logic [CH_W-1:0]    idx;
    logic               pop_ok;
    logic               clear_hit;
    logic [STAMP_W-1:0] lat_first;
    logic [STAMP_W-1:0] lat_second;
    logic [STAMP_W:0]   diff;
    logic [STAMP_W-1:0] abs_diff;
    logic [MOD_W-1:0]   modulus;
    logic [STAMP_W-1:0] rem16;
    logic [STAMP_W-1:0] p_mod;

    cpfm_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign idx     = CH_W'(link.cmd.channel);
    assign pop_ok  = pop & out_valid_reg;
    assign modulus = {1'b0, top_reg} + MOD_W'(1);

    assign clear_hit  = ~cap_reg[idx] & (ms_reg[idx] >= timeout_reg);
    assign lat_first  = clear_hit ? '0 : first_reg[idx];
    assign lat_second = clear_hit ? '0 : second_reg[idx];
    // (second - first) mod m equals the difference of the reduced stamps mod m
    assign diff       = {1'b0, lat_second} - {1'b0, lat_first};
    assign abs_diff   = diff[STAMP_W] ? (~diff[STAMP_W-1:0] + STAMP_W'(1))
                                      : diff[STAMP_W-1:0];

    assign rem16 = div_rsp.remainder[STAMP_W-1:0];
    assign p_mod = (neg_reg && rem16 != '0) ? STAMP_W'(modulus - {1'b0, rem16}) : rem16;

    always_comb
    begin
        state_next     = state_reg;
        clock_next     = clock_reg;
        top_next       = top_reg;
        timeout_next   = timeout_reg;
        first_next     = first_reg;
        second_next    = second_reg;
        per_next       = per_reg;
        freq_next      = freq_reg;
        ms_next        = ms_reg;
        pend_next      = pend_reg;
        cap_next       = cap_reg;
        ch_next        = ch_reg;
        neg_next       = neg_reg;
        p_next         = p_reg;
        f_next         = f_reg;
        out_valid_next = out_valid_reg & ~pop_ok;
        out_next       = out_reg;
        div_req        = '0;
        ready          = 1'b0;

        if (cfg_write)
        begin
            case (cfg_index)
                cpfm_pkg::REG_CLOCK:   clock_next   = cfg_data;
                cpfm_pkg::REG_TOP:     top_next     = cfg_data[STAMP_W-1:0];
                cpfm_pkg::REG_TIMEOUT: timeout_next = cfg_data[TIMEOUT_W-1:0];
                default: ;
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                ready = 1'b1;
                if (link.valid)
                begin
                    case (link.cmd.kind)
                        cpfm_pkg::KIND_TICK:
                        begin
                            for (int i = 0; i < CHANNELS; i++)
                            begin
                                if (ms_reg[i] != cpfm_pkg::MS_MAX)
                                begin
                                    ms_next[i] = ms_reg[i] + TIMEOUT_W'(1);
                                end
                            end
                        end
                        cpfm_pkg::KIND_CAPTURE:
                        begin
                            if (!pend_reg[idx])
                            begin
                                first_next[idx]  = link.cmd.first_stamp;
                                second_next[idx] = link.cmd.second_stamp;
                                pend_next[idx]   = 1'b1;
                            end
                            cap_next[idx] = 1'b1;
                            ms_next[idx]  = '0;
                        end
                        cpfm_pkg::KIND_POLL:
                        begin
                            ch_next       = idx;
                            cap_next[idx] = 1'b0;
                            p_next        = clear_hit ? '0 : per_reg[idx];
                            f_next        = clear_hit ? '0 : freq_reg[idx];
                            if (clear_hit)
                            begin
                                first_next[idx]  = '0;
                                second_next[idx] = '0;
                                per_next[idx]    = '0;
                                freq_next[idx]   = '0;
                            end
                            if (pend_reg[idx])
                            begin
                                pend_next[idx]   = 1'b0;
                                neg_next         = diff[STAMP_W];
                                div_req.start    = 1'b1;
                                div_req.dividend = {abs_diff, {cpfm_pkg::DIV_PAD_W{1'b0}}};
                                div_req.divisor  = modulus;
                                div_req.steps    = cpfm_pkg::DIV_CNT_W'(STAMP_W);
                                state_next       = ST_MOD;
                            end
                            else
                            begin
                                state_next = ST_OUT;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_MOD:
            begin
                if (div_rsp.done)
                begin
                    p_next          = p_mod;
                    per_next[ch_reg] = p_mod;
                    if (p_mod == '0)
                    begin
                        f_next            = '0;
                        freq_next[ch_reg] = '0;
                        state_next        = ST_OUT;
                    end
                    else
                    begin
                        div_req.start    = 1'b1;
                        div_req.dividend = clock_reg;
                        div_req.divisor  = {1'b0, p_mod};
                        div_req.steps    = cpfm_pkg::DIV_CNT_W'(cpfm_pkg::DIV_W);
                        state_next       = ST_FREQ;
                    end
                end
            end
            ST_FREQ:
            begin
                if (div_rsp.done)
                begin
                    // saturate quotients above 16 bits
                    f_next = (|div_rsp.quotient[CLOCK_W-1:STAMP_W]) ? cpfm_pkg::FREQ_MAX
                                                                   : div_rsp.quotient[STAMP_W-1:0];
                    freq_next[ch_reg] = f_next;
                    state_next        = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (!out_valid_reg || pop_ok)
                begin
                    out_valid_next          = 1'b1;
                    out_next.result_channel = ch_reg[0];
                    out_next.period_ticks   = p_reg;
                    out_next.frequency_hz   = f_reg;
                    state_next              = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            clock_reg     <= cpfm_pkg::CLOCK_RESET;
            top_reg       <= cpfm_pkg::TOP_RESET;
            timeout_reg   <= cpfm_pkg::TIMEOUT_RESET;
            pend_reg      <= '0;
            cap_reg       <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < CHANNELS; i++)
            begin
                first_reg[i]  <= '0;
                second_reg[i] <= '0;
                per_reg[i]    <= '0;
                freq_reg[i]   <= '0;
                ms_reg[i]     <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            clock_reg     <= clock_next;
            top_reg       <= top_next;
            timeout_reg   <= timeout_next;
            pend_reg      <= pend_next;
            cap_reg       <= cap_next;
            out_valid_reg <= out_valid_next;
            first_reg     <= first_next;
            second_reg    <= second_next;
            per_reg       <= per_next;
            freq_reg      <= freq_next;
            ms_reg        <= ms_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ch_reg  <= ch_next;
        neg_reg <= neg_next;
        p_reg   <= p_next;
        f_reg   <= f_next;
        out_reg <= out_next;
    end

    assign empty  = ~out_valid_reg;
    assign result = out_reg;

    // a pending pair always comes with a capture since the last poll
    a_pend_has_cap: assert property (@(posedge clk) disable iff (!rst_n)
        (pend_reg & ~cap_reg) == '0)
        else $error("pending pair without capture mark");

    a_div_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> (state_reg == ST_MOD || state_reg == ST_FREQ))
        else $error("divider finished outside a poll");

    a_freq_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FREQ) |-> (p_reg != '0))
        else $error("frequency division by zero period");

    a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_OUT && (!out_valid_reg || pop)) |=>
            (state_reg == ST_IDLE && out_valid_reg))
        else $error("result word not loaded");

    a_pop_keeps_data: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !pop) |=> (out_valid_reg && $stable(out_reg)))
        else $error("waiting result changed");

endmodule

[sv/capture_period_frequency_meter.sv]
// Channel  | Handshake          | Word
// ---------+--------------------+---------------------------------------------
// item     | push / full        | kind, channel, first_stamp, second_stamp
// result   | pop / empty        | result_channel, period_ticks, frequency_hz
// config   | cfg_write          | cfg_index selects clock, top or timeout
//
// Capture and tick words are taken in the back end's idle state; unused kinds
// and absent channels are dropped in the front and never reach it. A poll
// without a pending pair goes straight to output; with one, the shared
// restoring divider runs a 16-step modulo, then, for a nonzero period, a
// 27-step divide. A two-word queue parts the front from the back; a result
// register holds the waiting result while later words go on. rst_n clears all
// channel state and loads the register defaults at once; no clearing pass.
module capture_period_frequency_meter #(
    parameter int CHANNELS = cpfm_pkg::CHANNELS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    output logic                         full,
    input  cpfm_pkg::in_word_t           item,
    output logic                         empty,
    input  logic                         pop,
    output cpfm_pkg::res_word_t          result,
    input  logic                         cfg_write,
    input  logic [1:0]                   cfg_index,
    input  logic [cpfm_pkg::CLOCK_W-1:0] cfg_data
);

    cpfm_pkg::cmd_link_t link;
    logic                ready;

    cpfm_front #(
        .CHANNELS (CHANNELS)
    ) u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .full  (full),
        .item  (item),
        .link  (link),
        .ready (ready)
    );

    cpfm_back #(
        .CHANNELS (CHANNELS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .link      (link),
        .ready     (ready),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .empty     (empty),
        .pop       (pop),
        .result    (result)
    );

endmodule

[sim/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

    localparam int         STAMP_W      = cpfm_pkg::STAMP_W;
    localparam int         CLOCK_W      = cpfm_pkg::CLOCK_W;
    localparam int         TIMEOUT_W    = cpfm_pkg::TIMEOUT_W;
    localparam logic [1:0] KIND_UNUSED  = 2'd3;
    localparam int         DRAIN_CYCLES = 120;
    localparam int         HOLD_CYCLES  = 400;
    localparam int         MAX_REPORTS  = 50;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                push;
    logic                full;
    cpfm_pkg::in_word_t  item;
    logic                empty;
    logic                pop;
    cpfm_pkg::res_word_t result;
    logic                cfg_write;
    cpfm_pkg::cfg_reg_t  cfg_index;
    logic [CLOCK_W-1:0]  cfg_data;

    capture_period_frequency_meter u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .empty     (empty),
        .pop       (pop),
        .result    (result),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #10 clk = ~clk;

    // register image
    logic [CLOCK_W-1:0]   cfg_clock_hz;
    logic [STAMP_W-1:0]   cfg_top;
    logic [TIMEOUT_W-1:0] cfg_timeout;

    // per-channel meter state
    logic [STAMP_W-1:0]   ch_first   [2];
    logic [STAMP_W-1:0]   ch_second  [2];
    bit                   ch_pending [2];
    bit                   ch_fresh   [2];
    logic [TIMEOUT_W-1:0] ch_elapsed [2];
    logic [STAMP_W-1:0]   ch_period  [2];
    logic [STAMP_W-1:0]   ch_freq    [2];

    cpfm_pkg::res_word_t expected_readings[$];
    cpfm_pkg::res_word_t want;

    int errors        = 0;
    int n_items       = 0;
    int n_captures    = 0;
    int n_ticks       = 0;
    int n_polls       = 0;
    int n_readings    = 0;
    int n_reg_writes  = 0;
    int n_full_cycles = 0;

    // sender / receiver pacing
    int tx_gap_pct   = 0;
    int rx_stall_pct = 0;
    int burst_left   = 0;
    bit hold_req     = 1'b0;
    int hold_left    = 0;
    int rx_run       = 0;
    bit rx_stalling  = 1'b0;

    function automatic logic [STAMP_W-1:0] wrapped_span(logic [STAMP_W-1:0] a,
                                                        logic [STAMP_W-1:0] b,
                                                        logic [STAMP_W-1:0] top);
        int unsigned m;
        int unsigned x;
        int unsigned y;
        m = int'(top) + 1;
        x = a % m;
        y = b % m;
        return (y >= x) ? STAMP_W'(y - x) : STAMP_W'(m + y - x);
    endfunction

    function automatic logic [STAMP_W-1:0] rate_of(logic [CLOCK_W-1:0] clock_hz,
                                                   logic [STAMP_W-1:0] period);
        int unsigned q;
        if (period == 0)
            return '0;
        q = clock_hz / period;
        return (q > 65535) ? cpfm_pkg::FREQ_MAX : STAMP_W'(q);
    endfunction

    function automatic void clear_meter();
        for (int i = 0; i < 2; i++)
        begin
            ch_first[i]   = '0;
            ch_second[i]  = '0;
            ch_pending[i] = 1'b0;
            ch_fresh[i]   = 1'b0;
            ch_elapsed[i] = '0;
            ch_period[i]  = '0;
            ch_freq[i]    = '0;
        end
        cfg_clock_hz = cpfm_pkg::CLOCK_RESET;
        cfg_top      = cpfm_pkg::TOP_RESET;
        cfg_timeout  = cpfm_pkg::TIMEOUT_RESET;
    endfunction

    // advance the meter image by one accepted word
    function automatic void apply_word(cpfm_pkg::in_word_t w);
        int                  c;
        cpfm_pkg::res_word_t r;
        c = w.channel;
        n_items++;
        case (w.kind)
            cpfm_pkg::KIND_TICK:
            begin
                n_ticks++;
                for (int i = 0; i < 2; i++)
                    if (ch_elapsed[i] != cpfm_pkg::MS_MAX)
                        ch_elapsed[i]++;
            end
            cpfm_pkg::KIND_CAPTURE:
            begin
                n_captures++;
                if (!ch_pending[c])
                begin
                    ch_first[c]   = w.first_stamp;
                    ch_second[c]  = w.second_stamp;
                    ch_pending[c] = 1'b1;
                end
                ch_fresh[c]   = 1'b1;
                ch_elapsed[c] = '0;
            end
            cpfm_pkg::KIND_POLL:
            begin
                n_polls++;
                if (!ch_fresh[c] && ch_elapsed[c] >= cfg_timeout)
                begin
                    ch_first[c]  = '0;
                    ch_second[c] = '0;
                    ch_period[c] = '0;
                    ch_freq[c]   = '0;
                end
                if (ch_pending[c])
                begin
                    ch_period[c]  = wrapped_span(ch_first[c], ch_second[c], cfg_top);
                    ch_freq[c]    = rate_of(cfg_clock_hz, ch_period[c]);
                    ch_pending[c] = 1'b0;
                end
                ch_fresh[c] = 1'b0;
                r.result_channel = w.channel;
                r.period_ticks   = ch_period[c];
                r.frequency_hz   = ch_freq[c];
                expected_readings.push_back(r);
            end
            default: ;
        endcase
    endfunction

    function automatic cpfm_pkg::in_word_t make_word(logic [1:0] kind, logic ch,
                                                     logic [STAMP_W-1:0] a,
                                                     logic [STAMP_W-1:0] b);
        cpfm_pkg::in_word_t w;
        w.kind         = kind;
        w.channel      = ch;
        w.first_stamp  = a;
        w.second_stamp = b;
        return w;
    endfunction

    function automatic cpfm_pkg::in_word_t random_word();
        cpfm_pkg::in_word_t w;
        int                 r;
        w = make_word(cpfm_pkg::KIND_POLL, 1'($urandom), 16'($urandom), 16'($urandom));
        r = $urandom_range(0, 99);
        if (r < 35)
            w.kind = cpfm_pkg::KIND_CAPTURE;
        else if (r < 55)
            w.kind = cpfm_pkg::KIND_TICK;
        else if (r < 96)
            w.kind = cpfm_pkg::KIND_POLL;
        else
            w.kind = KIND_UNUSED;
        if (w.kind == cpfm_pkg::KIND_CAPTURE && $urandom_range(0, 2) == 0)
            w.second_stamp = w.first_stamp + 16'($urandom_range(0, 64));
        return w;
    endfunction

    task automatic send_word(cpfm_pkg::in_word_t w);
        if (burst_left == 0)
        begin
            if ($urandom_range(0, 99) < tx_gap_pct)
            begin
                @(negedge clk);
                push = 1'b0;
                repeat ($urandom_range(0, 7)) @(negedge clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        @(negedge clk);
        push = 1'b1;
        item = w;
        @(posedge clk);
        while (full)
            @(posedge clk);
        apply_word(w);
    endtask

    task automatic send(logic [1:0] kind, logic ch,
                        logic [STAMP_W-1:0] a = '0, logic [STAMP_W-1:0] b = '0);
        send_word(make_word(kind, ch, a, b));
    endtask

    task automatic send_ticks(int count);
        repeat (count) send(cpfm_pkg::KIND_TICK, 1'($urandom), 16'($urandom), 16'($urandom));
    endtask

    // block must be idle before a register write
    task automatic drain();
        @(negedge clk);
        push = 1'b0;
        while (expected_readings.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(cpfm_pkg::cfg_reg_t idx, logic [CLOCK_W-1:0] value);
        @(negedge clk);
        cfg_write = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        // unused upper data bits carry noise
        case (idx)
            cpfm_pkg::REG_CLOCK:   cfg_clock_hz = value;
            cpfm_pkg::REG_TOP:
            begin
                cfg_data[CLOCK_W-1:STAMP_W] = (CLOCK_W - STAMP_W)'($urandom);
                cfg_top = value[STAMP_W-1:0];
            end
            default:
            begin
                cfg_data[CLOCK_W-1:TIMEOUT_W] = (CLOCK_W - TIMEOUT_W)'($urandom);
                cfg_timeout = value[TIMEOUT_W-1:0];
            end
        endcase
        n_reg_writes++;
        @(negedge clk);
        cfg_write = 1'b0;
    endtask

    task automatic set_regs(logic [CLOCK_W-1:0] clock_hz, logic [STAMP_W-1:0] top,
                            logic [TIMEOUT_W-1:0] timeout);
        drain();
        write_reg(cpfm_pkg::REG_CLOCK, clock_hz);
        write_reg(cpfm_pkg::REG_TOP, CLOCK_W'(top));
        write_reg(cpfm_pkg::REG_TIMEOUT, CLOCK_W'(timeout));
    endtask

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && push && full)
            n_full_cycles++;
        if (rst_n && pop && !empty)
        begin
            n_readings++;
            if (expected_readings.size() == 0)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: word with none expected: ch %0d period %0d freq %0d",
                             $time, result.result_channel, result.period_ticks,
                             result.frequency_hz);
            end
            else
            begin
                want = expected_readings.pop_front();
                if (result !== want)
                begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                    begin
                        if (result.result_channel !== want.result_channel)
                            $display("%0t: result_channel expected %0d actual %0d", $time,
                                     want.result_channel, result.result_channel);
                        if (result.period_ticks !== want.period_ticks)
                            $display("%0t: period_ticks expected %0d actual %0d", $time,
                                     want.period_ticks, result.period_ticks);
                        if (result.frequency_hz !== want.frequency_hz)
                            $display("%0t: frequency_hz expected %0d actual %0d", $time,
                                     want.frequency_hz, result.frequency_hz);
                    end
                end
            end
        end
    end

    // receiver: runs of pops and stalls, plus a long hold-off on request
    initial
    begin
        pop = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                pop = 1'b0;
            end
            else
            begin
                if (rx_run == 0)
                begin
                    rx_run      = $urandom_range(1, 6);
                    rx_stalling = ($urandom_range(0, 99) < rx_stall_pct);
                end
                rx_run--;
                pop = !rx_stalling;
            end
        end
    end

    task automatic test_reset_defaults();
        tx_gap_pct   = 30;
        rx_stall_pct = 30;
        send(cpfm_pkg::KIND_POLL, 1'b0);
        send(cpfm_pkg::KIND_CAPTURE, 1'b0, 16'd0, 16'hFFFF);
        send(cpfm_pkg::KIND_CAPTURE, 1'b0, 16'd5, 16'd6);      // dropped, pair pending
        send(cpfm_pkg::KIND_POLL, 1'b0);
        send(cpfm_pkg::KIND_CAPTURE, 1'b1, 16'hFFFF, 16'd0);   // wraps to one tick
        send(cpfm_pkg::KIND_POLL, 1'b1);
        send(cpfm_pkg::KIND_POLL, 1'b1);                       // repeats last values
        send(cpfm_pkg::KIND_CAPTURE, 1'b0, 16'd1234, 16'd1234);
        send(cpfm_pkg::KIND_POLL, 1'b0);
        send(KIND_UNUSED, 1'b1, 16'hA5A5, 16'h5A5A);
        send(cpfm_pkg::KIND_CAPTURE, 1'b1, 16'd100, 16'd101);
        send(cpfm_pkg::KIND_POLL, 1'b1);
        send_ticks(15);
        send(cpfm_pkg::KIND_POLL, 1'b0);                       // timed out, cleared
    endtask

    task automatic test_register_extremes();
        set_regs(27'd100000000, 16'hFFFF, 8'd255);
        send(cpfm_pkg::KIND_CAPTURE, 1'b0, 16'd10, 16'd11);    // frequency saturates
        send(cpfm_pkg::KIND_POLL, 1'b0);
        send(cpfm_pkg::KIND_CAPTURE, 1'b1, 16'd0, 16'hFFFF);
        send(cpfm_pkg::KIND_POLL, 1'b1);
        send_ticks(300);                                       // ms count saturates
        send(cpfm_pkg::KIND_POLL, 1'b0);
        send(cpfm_pkg::KIND_POLL, 1'b1);

        set_regs('1, 16'd0, 8'd0);                             // top of zero, zero timeout
        send(cpfm_pkg::KIND_CAPTURE, 1'b0, 16'd40000, 16'd12);
        send(cpfm_pkg::KIND_POLL, 1'b0);
        send(cpfm_pkg::KIND_CAPTURE, 1'b1, 16'd3, 16'd9);
        send(cpfm_pkg::KIND_POLL, 1'b1);
        send(cpfm_pkg::KIND_POLL, 1'b1);
        send(cpfm_pkg::KIND_POLL, 1'b0);

        set_regs(27'd0, 16'd1, 8'd1);                          // zero clock
        send(cpfm_pkg::KIND_CAPTURE, 1'b1, 16'd2, 16'd7);
        send(cpfm_pkg::KIND_POLL, 1'b1);
        send(cpfm_pkg::KIND_TICK, 1'b0);
        send(cpfm_pkg::KIND_POLL, 1'b1);

        set_regs(27'd7, 16'd999, 8'd3);                        // stamps above top
        send(cpfm_pkg::KIND_CAPTURE, 1'b0, 16'hFFFF, 16'd3);
        send(cpfm_pkg::KIND_POLL, 1'b0);
        send_ticks(2);
        send(cpfm_pkg::KIND_POLL, 1'b0);
        send(cpfm_pkg::KIND_CAPTURE, 1'b0, 16'd50000, 16'd49000);
        send_ticks(3);
        send(cpfm_pkg::KIND_POLL, 1'b0);
    endtask

    task automatic test_backpressure();
        set_regs(cpfm_pkg::CLOCK_RESET, cpfm_pkg::TOP_RESET, cpfm_pkg::TIMEOUT_RESET);
        tx_gap_pct   = 0;
        rx_stall_pct = 0;
        @(negedge clk);
        hold_req = 1'b1;
        for (int i = 0; i < 16; i++)
        begin
            send(cpfm_pkg::KIND_CAPTURE, 1'(i), 16'($urandom), 16'($urandom));
            send(cpfm_pkg::KIND_POLL, 1'(i));
        end
    endtask

    task automatic set_random_regs();
        logic [CLOCK_W-1:0]   clock_hz;
        logic [STAMP_W-1:0]   top;
        logic [TIMEOUT_W-1:0] timeout;
        case ($urandom_range(0, 5))
            0:       clock_hz = '0;
            1:       clock_hz = 27'd1;
            2:       clock_hz = 27'd100000000;
            3:       clock_hz = '1;
            4:       clock_hz = 27'($urandom_range(1, 200000));
            default: clock_hz = 27'($urandom);
        endcase
        case ($urandom_range(0, 4))
            0:       top = '0;
            1:       top = 16'd1;
            2:       top = '1;
            3:       top = 16'($urandom_range(2, 1000));
            default: top = 16'($urandom);
        endcase
        case ($urandom_range(0, 4))
            0:       timeout = '0;
            1:       timeout = 8'd1;
            2:       timeout = '1;
            default: timeout = 8'($urandom_range(1, 20));
        endcase
        set_regs(clock_hz, top, timeout);
    endtask

    task automatic test_random_traffic(int phases, int per_phase);
        int sent;
        int pick;
        int k;
        logic ch;
        logic [STAMP_W-1:0] a;
        for (int p = 0; p < phases; p++)
        begin
            set_random_regs();
            case ($urandom_range(0, 2))
                0:       tx_gap_pct = 0;
                1:       tx_gap_pct = 30;
                default: tx_gap_pct = 70;
            endcase
            case ($urandom_range(0, 2))
                0:       rx_stall_pct = 0;
                1:       rx_stall_pct = 30;
                default: rx_stall_pct = 60;
            endcase
            sent = 0;
            while (sent < per_phase)
            begin
                pick = $urandom_range(0, 99);
                ch   = 1'($urandom);
                if (pick < 45)
                begin
                    // one measurement: capture, a few ticks, poll
                    a = 16'($urandom);
                    if ($urandom_range(0, 1))
                        send(cpfm_pkg::KIND_CAPTURE, ch, a, a + 16'($urandom_range(0, 300)));
                    else
                        send(cpfm_pkg::KIND_CAPTURE, ch, a, 16'($urandom));
                    k = $urandom_range(0, 3);
                    send_ticks(k);
                    send(cpfm_pkg::KIND_POLL, ch);
                    sent += 2 + k;
                end
                else if (pick < 48)
                begin
                    // run past the timeout
                    k = int'(cfg_timeout) + $urandom_range(0, 2);
                    if (k > 40 && $urandom_range(0, 3) != 0)
                        k = $urandom_range(1, 10);
                    send_ticks(k);
                    send(cpfm_pkg::KIND_POLL, ch);
                    sent += k + 1;
                end
                else
                begin
                    send_word(random_word());
                    sent++;
                end
            end
        end
    endtask

    initial
    begin
        rst_n     = 1'b0;
        push      = 1'b0;
        item      = '0;
        cfg_write = 1'b0;
        cfg_index = cpfm_pkg::REG_CLOCK;
        cfg_data  = '0;
        clear_meter();
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_defaults();
        test_register_extremes();
        test_backpressure();
        test_random_traffic(9, 150);

        drain();
        $display("covered %0d words (%0d captures, %0d ticks, %0d polls), %0d readings",
                 n_items, n_captures, n_ticks, n_polls, n_readings);
        $display("%0d register writes, %0d cycles with input held off by full",
                 n_reg_writes, n_full_cycles);
        if (errors == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("timeout with %0d readings outstanding", expected_readings.size());
        $display("tb_top: errors");
        $finish;
    end

endmodule
